@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the pad region walker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PRW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define PRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/prw_pkg.sv @@
// ----------------------------------------------------------------------------
// prw_pkg
// Widths, constants and inter-module types of the pad region walker.
// ----------------------------------------------------------------------------
package prw_pkg;

  // Region clip: columns and rows walked per hit
  localparam int MAX_SPAN  = 8;
  localparam int SPAN_LAST = MAX_SPAN - 1;

  // Field widths
  localparam int CRD_W = 19;   // hit coordinates
  localparam int HW_W  = 16;   // half-widths
  localparam int CFG_W = 12;   // pitches
  localparam int CNT_W = 8;    // pad counts
  localparam int IDX_W = 9;    // pad indices
  localparam int LIM_W = 22;   // integration limits

  // Shared divider: magnitude of a coordinate, or of a coordinate plus or minus a half-width
  localparam int DIV_W      = 20;
  localparam int DIV_BITS   = 2;                  // quotient bits per cycle
  localparam int DIV_CYC    = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);

  // Register reset values
  localparam logic [CFG_W-1:0] PAD_SIZE_X_RST  = CFG_W'(860);
  localparam logic [CFG_W-1:0] PAD_SIZE_Y_RST  = CFG_W'(860);
  localparam logic [CFG_W-1:0] WIRE_PITCH_RST  = CFG_W'(215);
  localparam logic [CNT_W-1:0] PAD_COUNT_X_RST = CNT_W'(160);
  localparam logic [CNT_W-1:0] PAD_COUNT_Y_RST = CNT_W'(144);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } prw_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [CFG_W-1:0] rem;
  } prw_div_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [IDX_W-1:0] min_x;
    logic signed [IDX_W-1:0] max_x;
    logic signed [IDX_W-1:0] min_y;
    logic signed [IDX_W-1:0] max_y;
    logic signed [LIM_W-1:0] xl0;
    logic signed [LIM_W-1:0] yl0;
  } prw_walk_cmd_t;

endpackage

@@ hdl/prw_div.sv @@
// ----------------------------------------------------------------------------
// prw_div
// Shared unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prw_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prw_pkg::prw_div_req_t req_i,
  output prw_pkg::prw_div_rsp_t rsp_o
);
  import prw_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     work_q, work_d;   // dividend out, quotient in
  logic [CFG_W-1:0]     rem_q, rem_d;
  logic [CFG_W-1:0]     dvs_q;

  logic [DIV_W-1:0]     step_w;
  logic [CFG_W-1:0]     step_r;
  logic [CFG_W:0]       part;

  // Two restoring steps per cycle
  always_comb begin
    step_w = work_q;
    step_r = rem_q;
    part   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      part   = {step_r, step_w[DIV_W-1]};
      step_w = {step_w[DIV_W-2:0], 1'b0};
      if (part >= {1'b0, dvs_q}) begin
        step_r    = CFG_W'(part - {1'b0, dvs_q});
        step_w[0] = 1'b1;
      end else begin
        step_r = part[CFG_W-1:0];
      end
    end
  end

  // Sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_CYC - 1);
      work_d = req_i.dividend;
      rem_d  = '0;
    end else if (busy_q) begin
      work_d = step_w;
      rem_d  = step_r;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q;
  assign rsp_o.rem  = rem_q;

  `PRW_ASSERT_IMPL(a_div_start_idle, clk_i, rst_ni, req_i.start, !busy_q)

endmodule

@@ hdl/prw_walk.sv @@
// ----------------------------------------------------------------------------
// prw_walk
// Pad walker: steps through the clipped region row by row, x inner, and
// holds each pad's result in the output register until transferred.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prw_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prw_pkg::prw_walk_cmd_t        cmd_i,
  input  logic [prw_pkg::CFG_W-1:0]     sx_i,
  input  logic [prw_pkg::CFG_W-1:0]     sy_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [prw_pkg::IDX_W-1:0] pad_x_o,
  output logic signed [prw_pkg::IDX_W-1:0] pad_y_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_x_low_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_x_high_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_y_low_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_y_high_o,
  output logic                          last_o
);
  import prw_pkg::*;

  logic                    valid_q;
  logic signed [IDX_W-1:0] cur_x_q, cur_y_q, min_x_q, max_x_q, max_y_q;
  logic signed [LIM_W-1:0] xl_row_q, xl_q, xh_q, yl_q, yh_q;
  logic signed [LIM_W-1:0] sx_e, sy_e;
  logic                    at_row_end, at_last, xfer;

  assign sx_e       = LIM_W'($signed({1'b0, sx_i}));
  assign sy_e       = LIM_W'($signed({1'b0, sy_i}));
  assign at_row_end = (cur_x_q == max_x_q);
  assign at_last    = at_row_end && (cur_y_q == max_y_q);
  assign xfer       = valid_q && out_ready_i;

  // Output register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.start) begin
      valid_q <= 1'b1;
    end else if (xfer && at_last) begin
      valid_q <= 1'b0;
    end
  end

  // Position and limits: limits move by one pitch per pad
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      min_x_q  <= $signed(cmd_i.min_x);
      max_x_q  <= $signed(cmd_i.max_x);
      max_y_q  <= $signed(cmd_i.max_y);
      cur_x_q  <= $signed(cmd_i.min_x);
      cur_y_q  <= $signed(cmd_i.min_y);
      xl_row_q <= $signed(cmd_i.xl0);
      xl_q     <= $signed(cmd_i.xl0);
      xh_q     <= $signed(cmd_i.xl0) + sx_e;
      yl_q     <= $signed(cmd_i.yl0);
      yh_q     <= $signed(cmd_i.yl0) + sy_e;
    end else if (xfer && !at_last) begin
      if (at_row_end) begin
        cur_x_q <= min_x_q;
        cur_y_q <= cur_y_q + IDX_W'(1);
        xl_q    <= xl_row_q;
        xh_q    <= xl_row_q + sx_e;
        yl_q    <= yl_q - sy_e;
        yh_q    <= yl_q;
      end else begin
        cur_x_q <= cur_x_q + IDX_W'(1);
        xl_q    <= xl_q - sx_e;
        xh_q    <= xl_q;
      end
    end
  end

  assign busy_o         = valid_q;
  assign out_valid_o    = valid_q;
  assign pad_x_o        = cur_x_q;
  assign pad_y_o        = cur_y_q;
  assign limit_x_low_o  = xl_q;
  assign limit_x_high_o = xh_q;
  assign limit_y_low_o  = yl_q;
  assign limit_y_high_o = yh_q;
  assign last_o         = at_last;

  `PRW_ASSERT_NEXT(a_walk_ends_on_last, clk_i, rst_ni, xfer && at_last && !cmd_i.start, !valid_q)
  `PRW_ASSERT_IMPL(a_walk_in_region, clk_i, rst_ni, valid_q, (cur_x_q <= max_x_q) && (cur_y_q <= max_y_q))

endmodule

@@ hdl/pad_region_walker.sv @@
// ----------------------------------------------------------------------------
// pad_region_walker
// Snaps a hit to its anode-wire cell, finds the covered pad rectangle and
// emits one result per pad with integration limits relative to that pad.
// ----------------------------------------------------------------------------
// One hit at a time: after a transfer on the input the block runs five
// divisions on one shared divider (wire snap, then the low and high pad
// index along x and along y), each an operand load, ten radix-4
// iterations and a result, then sets up the walk in the MULX, MULY and
// LAUNCH states, then emits one result per cycle while the output side is
// ready, up to 64 pads for a region clipped to 8 by 8. A zero pitch acts
// as one, and a hit always yields at least one pad.
`include "assert_macros.svh"

module pad_region_walker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // register write port
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [prw_pkg::CFG_W-1:0]        cfg_data_i,
  // hit input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [prw_pkg::CRD_W-1:0] hit_x_i,
  input  logic signed [prw_pkg::CRD_W-1:0] hit_y_i,
  input  logic [prw_pkg::HW_W-1:0]         half_width_x_i,
  input  logic [prw_pkg::HW_W-1:0]         half_width_y_i,
  // pad results
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [prw_pkg::IDX_W-1:0] pad_x_o,
  output logic signed [prw_pkg::IDX_W-1:0] pad_y_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_x_low_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_x_high_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_y_low_o,
  output logic signed [prw_pkg::LIM_W-1:0] limit_y_high_o,
  output logic                             last_o
);
  import prw_pkg::*;

  // Register indexes
  localparam logic [2:0] REG_PAD_SIZE_X  = 3'd0;
  localparam logic [2:0] REG_PAD_SIZE_Y  = 3'd1;
  localparam logic [2:0] REG_WIRE_PITCH  = 3'd2;
  localparam logic [2:0] REG_PAD_COUNT_X = 3'd3;
  localparam logic [2:0] REG_PAD_COUNT_Y = 3'd4;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MULX   = 3'd3;
  localparam logic [2:0] ST_MULY   = 3'd4;
  localparam logic [2:0] ST_LAUNCH = 3'd5;
  localparam logic [2:0] ST_WALK   = 3'd6;

  // Division jobs, in issue order
  localparam logic [2:0] OP_SNAP = 3'd0;
  localparam logic [2:0] OP_MINX = 3'd1;
  localparam logic [2:0] OP_MAXX = 3'd2;
  localparam logic [2:0] OP_MINY = 3'd3;
  localparam logic [2:0] OP_MAXY = 3'd4;

  localparam int SW = DIV_W + 1;
  localparam logic signed [SW-1:0] SNAP_HI = SW'(2 ** (CRD_W - 1) - 1);
  localparam logic signed [SW-1:0] SNAP_LO = -SW'(2 ** (CRD_W - 1));

  // Configuration registers
  logic [CFG_W-1:0] pad_size_x_q, pad_size_y_q, wire_pitch_q;
  logic [CNT_W-1:0] pad_count_x_q, pad_count_y_q;
  logic [CFG_W-1:0] sx_eff, sy_eff, wp_eff;

  logic [2:0]              state_q, state_d;
  logic [2:0]              op_q;
  logic signed [CRD_W-1:0] hit_x_q, hit_y_q, snap_q;
  logic [HW_W-1:0]         hw_x_q, hw_y_q;
  logic signed [IDX_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [LIM_W-1:0] xl0_q, yl0_q;
  logic                    c_neg_q, c_pos_q;

  prw_div_req_t  div_req;
  prw_div_rsp_t  div_rsp;
  prw_walk_cmd_t walk_cmd;
  logic          walk_busy;

  logic signed [DIV_W-1:0] c_val;
  logic [CFG_W-1:0]        dvs_sel;
  logic [CNT_W-1:0]        n_sel;
  logic signed [SW-1:0]    idx_raw, n_s, idx_cl;
  logic signed [IDX_W-1:0] idx;
  logic signed [IDX_W:0]   clip_lim;
  logic signed [IDX_W-1:0] idx_clip;
  logic signed [SW-1:0]    x_e, r_e, h_e, base, snap_raw;
  logic signed [CRD_W-1:0] snap_new;
  logic signed [LIM_W-1:0] mul_a, mul_b, mul_base, mul_res;

  assign sx_eff = (pad_size_x_q == '0) ? CFG_W'(1) : pad_size_x_q;
  assign sy_eff = (pad_size_y_q == '0) ? CFG_W'(1) : pad_size_y_q;
  assign wp_eff = (wire_pitch_q == '0) ? CFG_W'(1) : wire_pitch_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_size_x_q  <= PAD_SIZE_X_RST;
      pad_size_y_q  <= PAD_SIZE_Y_RST;
      wire_pitch_q  <= WIRE_PITCH_RST;
      pad_count_x_q <= PAD_COUNT_X_RST;
      pad_count_y_q <= PAD_COUNT_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAD_SIZE_X:  pad_size_x_q  <= cfg_data_i;
        REG_PAD_SIZE_Y:  pad_size_y_q  <= cfg_data_i;
        REG_WIRE_PITCH:  wire_pitch_q  <= cfg_data_i;
        REG_PAD_COUNT_X: pad_count_x_q <= cfg_data_i[CNT_W-1:0];
        REG_PAD_COUNT_Y: pad_count_y_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operand for the current job
  always_comb begin
    case (op_q)
      OP_SNAP: begin
        c_val   = DIV_W'(hit_x_q);
        dvs_sel = wp_eff;
      end
      OP_MINX: begin
        c_val   = DIV_W'(snap_q) - DIV_W'($signed({1'b0, hw_x_q}));
        dvs_sel = sx_eff;
      end
      OP_MAXX: begin
        c_val   = DIV_W'(snap_q) + DIV_W'($signed({1'b0, hw_x_q}));
        dvs_sel = sx_eff;
      end
      OP_MINY: begin
        c_val   = DIV_W'(hit_y_q) - DIV_W'($signed({1'b0, hw_y_q}));
        dvs_sel = sy_eff;
      end
      default: begin
        c_val   = DIV_W'(hit_y_q) + DIV_W'($signed({1'b0, hw_y_q}));
        dvs_sel = sy_eff;
      end
    endcase
  end

  assign div_req.start    = (state_q == ST_LOAD);
  assign div_req.divisor  = dvs_sel;
  assign div_req.dividend = c_val[DIV_W-1] ? DIV_W'(-c_val) : DIV_W'(c_val);

  // Pad index from the quotient: sign, plus one above zero, clamp to count
  always_comb begin
    n_sel = ((op_q == OP_MINX) || (op_q == OP_MAXX)) ? pad_count_x_q : pad_count_y_q;
    n_s   = $signed({{(SW - CNT_W){1'b0}}, n_sel});
    if (c_neg_q) begin
      idx_raw = -$signed({1'b0, div_rsp.quot});
    end else begin
      idx_raw = $signed({1'b0, div_rsp.quot}) + $signed({{DIV_W{1'b0}}, c_pos_q});
    end
    if (idx_raw > n_s) begin
      idx_cl = n_s;
    end else if (idx_raw < -n_s) begin
      idx_cl = -n_s;
    end else begin
      idx_cl = idx_raw;
    end
    idx = IDX_W'(idx_cl);
  end

  // High index clipped to SPAN_LAST past the low one
  always_comb begin
    clip_lim = ((op_q == OP_MAXX) ? (IDX_W+1)'(min_x_q) : (IDX_W+1)'(min_y_q))
               + (IDX_W+1)'(SPAN_LAST);
    idx_clip = ((IDX_W+1)'(idx) > clip_lim) ? IDX_W'(clip_lim) : idx;
  end

  // Wire-cell snap from the truncated remainder, saturated
  always_comb begin
    x_e  = SW'(hit_x_q);
    r_e  = $signed({{(SW - CFG_W){1'b0}}, div_rsp.rem});
    h_e  = $signed({{(SW - CFG_W + 1){1'b0}}, wp_eff[CFG_W-1:1]});
    base = (hit_x_q < 0) ? (x_e + r_e) : (x_e - r_e);
    snap_raw = (hit_x_q > 0) ? (base + h_e) : (base - h_e);
    if (snap_raw > SNAP_HI) begin
      snap_new = CRD_W'(SNAP_HI);
    end else if (snap_raw < SNAP_LO) begin
      snap_new = CRD_W'(SNAP_LO);
    end else begin
      snap_new = CRD_W'(snap_raw);
    end
  end

  // Shared multiplier: low limit of the first pad in x, then in y
  always_comb begin
    if (state_q == ST_MULX) begin
      mul_a    = LIM_W'(min_x_q);
      mul_b    = LIM_W'($signed({1'b0, sx_eff}));
      mul_base = LIM_W'(snap_q);
    end else begin
      mul_a    = LIM_W'(min_y_q);
      mul_b    = LIM_W'($signed({1'b0, sy_eff}));
      mul_base = LIM_W'(hit_y_q);
    end
    mul_res = mul_base - mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = (op_q == OP_MAXY) ? ST_MULX : ST_LOAD;
        end
      end
      ST_MULX:   state_d = ST_MULY;
      ST_MULY:   state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_WALK;
      ST_WALK:   if (!walk_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SNAP;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        op_q <= OP_SNAP;
      end else if ((state_q == ST_DIV) && div_rsp.done) begin
        op_q <= op_q + 3'd1;
      end
    end
  end

  // Item data and job results
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      hit_x_q <= hit_x_i;
      hit_y_q <= hit_y_i;
      hw_x_q  <= half_width_x_i;
      hw_y_q  <= half_width_y_i;
    end
    if (state_q == ST_LOAD) begin
      c_neg_q <= c_val < 0;
      c_pos_q <= c_val > 0;
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      case (op_q)
        OP_SNAP: snap_q  <= snap_new;
        OP_MINX: min_x_q <= idx;
        OP_MAXX: max_x_q <= idx_clip;
        OP_MINY: min_y_q <= idx;
        OP_MAXY: max_y_q <= idx_clip;
        default: ;
      endcase
    end
    if (state_q == ST_MULX) begin
      xl0_q <= mul_res;
    end
    if (state_q == ST_MULY) begin
      yl0_q <= mul_res;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  assign walk_cmd.start = (state_q == ST_LAUNCH);
  assign walk_cmd.min_x = min_x_q;
  assign walk_cmd.max_x = max_x_q;
  assign walk_cmd.min_y = min_y_q;
  assign walk_cmd.max_y = max_y_q;
  assign walk_cmd.xl0   = xl0_q;
  assign walk_cmd.yl0   = yl0_q;

  prw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  prw_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (walk_cmd),
    .sx_i           (sx_eff),
    .sy_i           (sy_eff),
    .busy_o         (walk_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pad_x_o        (pad_x_o),
    .pad_y_o        (pad_y_o),
    .limit_x_low_o  (limit_x_low_o),
    .limit_x_high_o (limit_x_high_o),
    .limit_y_low_o  (limit_y_low_o),
    .limit_y_high_o (limit_y_high_o),
    .last_o         (last_o)
  );

  `PRW_ASSERT_IMPL(a_no_result_while_ready, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `PRW_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni, div_rsp.done, state_q == ST_DIV)

endmodule
